// ===== rtl/mnhe_pkg.sv =====
// Shared types, constants and helper functions for the neo-Hookean energy block.
`default_nettype none
package mnhe_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_JAC = 2'd1;
  localparam logic [1:0] ST_NO_AREA = 2'd2;

  // ln(1+f) table: 2^LN_TAB_BITS intervals over f in [0,1), Q30 entries
  localparam int LN_TAB_BITS = 8;
  localparam int LN_SH       = 30 - LN_TAB_BITS;
  localparam int LN_TAB_SIZE = (1 << LN_TAB_BITS) + 1;
  localparam int LN_IDX_W    = LN_TAB_BITS + 1;
  localparam logic signed [31:0] LN2_Q30 = 32'sd744261118;

  // Element queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [31:0] f00;
    logic signed [31:0] f01;
    logic signed [31:0] f10;
    logic signed [31:0] f11;
    logic [30:0]        bulk_modulus;
    logic [30:0]        shear_modulus;
    logic [30:0]        elem_area;
    logic               last_element;
  } elem_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    logic signed [63:0] r;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Shift-subtract division, used only while building the log table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] r;
    logic [63:0] q;
    int i;
    r = 64'd0;
    q = 64'd0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + k/2^LN_TAB_BITS) in Q30 via the atanh series
  function automatic logic [30:0] ln1p_entry(input int k);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] sum;
    int n;
    x    = 64'(k) << LN_SH;
    y    = udiv64(x << 30, (64'd1 << 31) + x);
    y2   = (y * y) >> 30;
    term = y;
    sum  = 64'd0;
    for (n = 0; n < 16; n++) begin
      sum  = sum + udiv64(term, 64'(2 * n + 1));
      term = (term * y2) >> 30;
    end
    return 31'(sum << 1);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mnhe_fifo.sv =====
// Two-entry element queue between the node front end and the energy back end.
`default_nettype none
module mnhe_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  mnhe_pkg::elem_t      push_data,
  output logic                 full,
  input  wire logic            pop,
  output mnhe_pkg::elem_t      head,
  output logic                 empty
);

  mnhe_pkg::elem_t                  mem [mnhe_pkg::QDEPTH];
  logic [mnhe_pkg::QAW-1:0]         wr_ptr;
  logic [mnhe_pkg::QAW-1:0]         rd_ptr;
  logic [mnhe_pkg::QAW:0]           count;

  assign full  = (count == (mnhe_pkg::QAW + 1)'(mnhe_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mnhe_front.sv =====
// Node front end: takes node requests, accumulates F - I, queues finished elements.
`default_nettype none
module mnhe_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               node_valid,
  output logic                    node_ready,
  input  wire logic signed [31:0] disp_x,
  input  wire logic signed [31:0] disp_y,
  input  wire logic signed [31:0] grad_b,
  input  wire logic signed [31:0] grad_c,
  input  wire logic [30:0]        bulk_modulus,
  input  wire logic [30:0]        shear_modulus,
  input  wire logic [30:0]        elem_area,
  input  wire logic               last_element,
  output logic                    q_push,
  output mnhe_pkg::elem_t         q_data,
  input  wire logic               q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  logic [1:0]         state;
  logic [2:0]         cnt;
  logic [1:0]         node_index;
  logic signed [31:0] ux, uy, gb, gc;
  logic [30:0]        lam, mu, area;
  logic               last;
  logic signed [63:0] prod;
  logic signed [63:0] prod_f;
  logic signed [63:0] acc00, acc01, acc10, acc11;
  logic signed [31:0] mul_a, mul_b;

  assign node_ready = (state == F_IDLE);
  assign q_push     = (state == F_PUSH) && !q_full;
  assign prod_f     = prod >>> FRAC_BITS;

  // select: 00 x*b, 01 x*c, 10 y*b, 11 y*c
  assign mul_a = cnt[1] ? uy : ux;
  assign mul_b = cnt[0] ? gc : gb;

  always_comb begin
    q_data.f00           = mnhe_pkg::sat32(acc00 + ONE);
    q_data.f01           = mnhe_pkg::sat32(acc01);
    q_data.f10           = mnhe_pkg::sat32(acc10);
    q_data.f11           = mnhe_pkg::sat32(acc11 + ONE);
    q_data.bulk_modulus  = lam;
    q_data.shear_modulus = mu;
    q_data.elem_area     = area;
    q_data.last_element  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      cnt        <= '0;
      node_index <= '0;
      acc00      <= '0;
      acc01      <= '0;
      acc10      <= '0;
      acc11      <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (node_valid) begin
            ux    <= disp_x;
            uy    <= disp_y;
            gb    <= grad_b;
            gc    <= grad_c;
            lam   <= bulk_modulus;
            mu    <= shear_modulus;
            area  <= elem_area;
            last  <= last_element;
            cnt   <= '0;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          if (cnt != 3'd4) begin
            prod <= mul_a * mul_b;
          end
          case (cnt)
            3'd1:    acc00 <= acc00 + prod_f;
            3'd2:    acc01 <= acc01 + prod_f;
            3'd3:    acc10 <= acc10 + prod_f;
            3'd4:    acc11 <= acc11 + prod_f;
            default: ;
          endcase
          cnt <= cnt + 1'b1;
          if (cnt == 3'd4) begin
            if (node_index == 2'd2) begin
              state <= F_PUSH;
            end else begin
              node_index <= node_index + 1'b1;
              state      <= F_IDLE;
            end
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            node_index <= '0;
            acc00      <= '0;
            acc01      <= '0;
            acc10      <= '0;
            acc11      <= '0;
            state      <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mnhe_div.sv =====
// Restoring divider: signed 64-bit sum over unsigned 48-bit area, saturated to 32 bits.
`default_nettype none
module mnhe_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [47:0]        divisor,
  output logic                    done,
  output logic signed [31:0]      quotient
);

  logic        run;
  logic        fix;
  logic [5:0]  cnt;
  logic        neg;
  logic [63:0] quo;
  logic [47:0] rem;
  logic [48:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem, quo[63]};
  assign fits   = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= dividend[63];
        quo <= dividend[63] ? 64'(-dividend) : 64'(dividend);
        rem <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= fits ? 48'(rem_sh - {1'b0, divisor}) : rem_sh[47:0];
        quo <= {quo[62:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          run <= 1'b0;
          fix <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
        if (neg) begin
          quotient <= (quo > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : 32'(-quo[31:0]);
        end else begin
          quotient <= (quo > 64'h0000_0000_7fff_ffff) ? 32'sh7fff_ffff : quo[31:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mnhe_back.sv =====
// Element back end: J, trace, ln J, element energy, running sums and final mean.
`default_nettype none
module mnhe_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  mnhe_pkg::elem_t         q_head,
  output logic                    q_pop,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic signed [31:0]      mean_energy,
  output logic [1:0]              status
);

  localparam logic [4:0] B_IDLE = 5'd0;
  localparam logic [4:0] B_M0   = 5'd1;
  localparam logic [4:0] B_M1   = 5'd2;
  localparam logic [4:0] B_M2   = 5'd3;
  localparam logic [4:0] B_M3   = 5'd4;
  localparam logic [4:0] B_M4   = 5'd5;
  localparam logic [4:0] B_M5   = 5'd6;
  localparam logic [4:0] B_M6   = 5'd7;
  localparam logic [4:0] B_M7   = 5'd8;
  localparam logic [4:0] B_M8   = 5'd9;
  localparam logic [4:0] B_M9   = 5'd10;
  localparam logic [4:0] B_M10  = 5'd11;
  localparam logic [4:0] B_NORM = 5'd12;
  localparam logic [4:0] B_TAB  = 5'd13;
  localparam logic [4:0] B_INT  = 5'd14;
  localparam logic [4:0] B_LN1  = 5'd15;
  localparam logic [4:0] B_LN2  = 5'd16;
  localparam logic [4:0] B_T3   = 5'd17;
  localparam logic [4:0] B_WE   = 5'd18;
  localparam logic [4:0] B_EW   = 5'd19;
  localparam logic [4:0] B_ACC  = 5'd20;
  localparam logic [4:0] B_FIN  = 5'd21;
  localparam logic [4:0] B_DIV  = 5'd22;
  localparam logic [4:0] B_OUT  = 5'd23;

  localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] TWO_ONE = 64'sd2 <<< FRAC_BITS;
  localparam logic [47:0]        AREA_MAX = {48{1'b1}};

  logic [4:0]                        state;
  mnhe_pkg::elem_t                   el;
  logic signed [63:0]                prod, prod_f, prod_f1;
  logic signed [31:0]                mul_a, mul_b;
  logic signed [63:0]                jac, trc, t1, t2;
  logic signed [31:0]                dreg, dsat, trm, lsat, we;
  logic [63:0]                       u;
  logic [6:0]                        lz, pos;
  logic [2:0]                        ncnt;
  logic [30:0]                       lo, hi;
  logic [mnhe_pkg::LN_SH-1:0]        rfrac;
  logic [31:0]                       frac;
  logic signed [31:0]                pf;
  logic signed [63:0]                l30, wsum;
  logic signed [63:0]                energy;
  logic [47:0]                       area_sum;
  logic [48:0]                       area_next;
  logic                              bad;
  logic signed [31:0]                pend_mean;
  logic [1:0]                        pend_stat;
  logic [mnhe_pkg::LN_TAB_BITS-1:0]  idx;
  logic [mnhe_pkg::LN_IDX_W-1:0]     idx_lo;
  logic [30:0]                       ln_tab [mnhe_pkg::LN_TAB_SIZE];
  logic                              div_start, div_done;
  logic signed [31:0]                div_q;

  for (genvar k = 0; k < mnhe_pkg::LN_TAB_SIZE; k++) begin : g_tab
    localparam logic [30:0] ENTRY = mnhe_pkg::ln1p_entry(k);
    assign ln_tab[k] = ENTRY;
  end

  assign prod_f    = prod >>> FRAC_BITS;
  assign prod_f1   = prod >>> (FRAC_BITS + 1);
  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign area_next = {1'b0, area_sum} + 49'(q_head.elem_area);
  assign idx       = u[62 -: mnhe_pkg::LN_TAB_BITS];
  assign idx_lo    = {1'b0, idx};
  assign pf        = 32'($signed({1'b0, pos})) - 32'(FRAC_BITS);
  assign l30       = prod + $signed({32'd0, frac});
  assign wsum      = t1 + t2 - prod_f;
  assign div_start = (state == B_FIN) && el.last_element && !bad && (area_sum != '0);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      B_M0:    begin mul_a = el.f00; mul_b = el.f11; end
      B_M1:    begin mul_a = el.f01; mul_b = el.f10; end
      B_M2:    begin mul_a = el.f00; mul_b = el.f00; end
      B_M3:    begin mul_a = el.f01; mul_b = el.f01; end
      B_M4:    begin mul_a = el.f10; mul_b = el.f10; end
      B_M5:    begin mul_a = el.f11; mul_b = el.f11; end
      B_M6:    begin mul_a = dreg;   mul_b = dreg;   end
      B_M8:    begin mul_a = $signed({1'b0, el.shear_modulus}); mul_b = trm; end
      B_M9:    begin mul_a = $signed({1'b0, el.bulk_modulus});  mul_b = dsat; end
      B_INT:   begin
        mul_a = $signed({1'b0, 31'(hi - lo)});
        mul_b = $signed(32'(rfrac));
      end
      B_LN1:   begin mul_a = pf; mul_b = mnhe_pkg::LN2_Q30; end
      B_T3:    begin mul_a = $signed({1'b0, el.shear_modulus}); mul_b = lsat; end
      B_EW:    begin mul_a = $signed({1'b0, el.elem_area});     mul_b = we; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      energy       <= '0;
      area_sum     <= '0;
      bad          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // B_OUT drives result_valid itself
      if (result_ready && state != B_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            el       <= q_head;
            area_sum <= area_next[48] ? AREA_MAX : area_next[47:0];
            state    <= B_M0;
          end
        end
        B_M0: state <= B_M1;
        B_M1: begin
          jac   <= prod_f;
          state <= B_M2;
        end
        B_M2: begin
          jac   <= jac - prod_f;
          state <= B_M3;
        end
        B_M3: begin
          trc   <= prod_f;
          dreg  <= mnhe_pkg::sat32(jac - ONE);
          state <= B_M4;
        end
        B_M4: begin
          trc   <= trc + prod_f;
          state <= B_M5;
        end
        B_M5: begin
          trc   <= trc + prod_f;
          state <= B_M6;
        end
        B_M6: begin
          trc   <= trc + prod_f;
          state <= B_M7;
        end
        B_M7: begin
          dsat  <= mnhe_pkg::sat32(prod_f);
          trm   <= mnhe_pkg::sat32(trc - TWO_ONE);
          state <= B_M8;
        end
        B_M8: state <= B_M9;
        B_M9: begin
          t1    <= prod_f1;
          state <= B_M10;
        end
        B_M10: begin
          t2 <= prod_f1;
          if (jac <= 64'sd0) begin
            bad   <= 1'b1;
            state <= B_FIN;
          end else begin
            u     <= jac;
            lz    <= '0;
            ncnt  <= '0;
            state <= B_NORM;
          end
        end
        // leading-one search, halving the step each cycle
        B_NORM: begin
          ncnt <= ncnt + 1'b1;
          case (ncnt)
            3'd0: if (u[63:32] == '0) begin u <= u << 32; lz <= lz + 7'd32; end
            3'd1: if (u[63:48] == '0) begin u <= u << 16; lz <= lz + 7'd16; end
            3'd2: if (u[63:56] == '0) begin u <= u << 8;  lz <= lz + 7'd8;  end
            3'd3: if (u[63:60] == '0) begin u <= u << 4;  lz <= lz + 7'd4;  end
            3'd4: if (u[63:62] == '0) begin u <= u << 2;  lz <= lz + 7'd2;  end
            default: if (!u[63]) begin u <= u << 1; lz <= lz + 7'd1; end
          endcase
          if (ncnt == 3'd5) begin
            state <= B_TAB;
          end
        end
        B_TAB: begin
          lo    <= ln_tab[idx_lo];
          hi    <= ln_tab[idx_lo + mnhe_pkg::LN_IDX_W'(1)];
          rfrac <= u[62 - mnhe_pkg::LN_TAB_BITS -: mnhe_pkg::LN_SH];
          pos   <= 7'd63 - lz;
          state <= B_INT;
        end
        B_INT: state <= B_LN1;
        B_LN1: begin
          frac  <= 32'({1'b0, lo}) + prod[mnhe_pkg::LN_SH + 31 : mnhe_pkg::LN_SH];
          state <= B_LN2;
        end
        B_LN2: begin
          lsat  <= mnhe_pkg::sat32(l30 >>> (30 - FRAC_BITS));
          state <= B_T3;
        end
        B_T3: state <= B_WE;
        B_WE: begin
          we    <= mnhe_pkg::sat32(wsum);
          state <= B_EW;
        end
        B_EW: state <= B_ACC;
        B_ACC: begin
          energy <= mnhe_pkg::sat_add64(energy, prod);
          state  <= B_FIN;
        end
        B_FIN: begin
          if (!el.last_element) begin
            state <= B_IDLE;
          end else if (bad) begin
            pend_mean <= '0;
            pend_stat <= mnhe_pkg::ST_BAD_JAC;
            state     <= B_OUT;
          end else if (area_sum == '0) begin
            pend_mean <= '0;
            pend_stat <= mnhe_pkg::ST_NO_AREA;
            state     <= B_OUT;
          end else begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (div_done) begin
            pend_mean <= div_q;
            pend_stat <= mnhe_pkg::ST_OK;
            state     <= B_OUT;
          end
        end
        B_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            mean_energy  <= pend_mean;
            status       <= pend_stat;
            energy       <= '0;
            area_sum     <= '0;
            bad          <= 1'b0;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  mnhe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (energy),
    .divisor  (area_sum),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
`default_nettype wire

// ===== rtl/mean_neo_hookean_energy_tri.sv =====
// Top level: area-weighted mean neo-Hookean energy over a stream of triangles.
//
// Usage: each triangle arrives as three node requests on node_valid/node_ready,
// carrying displacement (disp_x, disp_y), shape gradient (grad_b, grad_c) and,
// on the third node, lambda, mu, area and last_element. All values Q.FRAC_BITS.
// The front end takes one node at a time on one shared 32x32 multiplier
// (four products per node), then queues each finished element, waiting while the queue is full.
// A two-entry element queue decouples it from the back end, which evaluates
// J, trace(C), ln J and the element energy on its own shared multiplier
// (skipping the log path when J <= 0). Sustained throughput is set by the
// back end while J > 0, and by the front end when J <= 0.
// On the third node of the last element, one result comes out on
// result_valid/result_ready: the mean (by restoring divide) or a status
// code with zero.
// The result sits in an output register; a stalled receiver holds it there
// while the back end keeps working until it has a second result to deliver.
// Synchronous reset clears the node position, partial F, the sums and the
// error flag; the log table is constant logic and needs no fill.
`default_nettype none
module mean_neo_hookean_energy_tri #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               node_valid,
  output logic                    node_ready,
  input  wire logic signed [31:0] disp_x,
  input  wire logic signed [31:0] disp_y,
  input  wire logic signed [31:0] grad_b,
  input  wire logic signed [31:0] grad_c,
  input  wire logic [30:0]        bulk_modulus,
  input  wire logic [30:0]        shear_modulus,
  input  wire logic [30:0]        elem_area,
  input  wire logic               last_element,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic signed [31:0]      mean_energy,
  output logic [1:0]              status
);

  mnhe_pkg::elem_t q_in, q_head;
  logic            q_push, q_full, q_pop, q_empty;

  // front: node requests -> partial deformation gradient -> element record
  mnhe_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .node_valid    (node_valid),
    .node_ready    (node_ready),
    .disp_x        (disp_x),
    .disp_y        (disp_y),
    .grad_b        (grad_b),
    .grad_c        (grad_c),
    .bulk_modulus  (bulk_modulus),
    .shear_modulus (shear_modulus),
    .elem_area     (elem_area),
    .last_element  (last_element),
    .q_push        (q_push),
    .q_data        (q_in),
    .q_full        (q_full)
  );

  mnhe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // back: element energy, sums, final mean or status
  mnhe_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .mean_energy  (mean_energy),
    .status       (status)
  );

  // error statuses always carry a zero mean
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != mnhe_pkg::ST_OK) |-> (mean_energy == 32'sd0))
    else $error("nonzero mean with error status");

  // nothing is reported straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // the queue is never pushed while full and never popped while empty
  a_queue_safe: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full) && !(q_pop && q_empty))
    else $error("element queue overrun or underrun");

endmodule
`default_nettype wire

// ===== bench/mean_neo_hookean_energy_tri_tb.sv =====
// Self-checking bench for the mean neo-Hookean triangle energy block.
`timescale 1ns / 1ps
module mean_neo_hookean_energy_tri_tb;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam longint LN2_FIXED = 64'sd744261118;
  localparam longint unsigned AREA_CAP = (64'd1 << 48) - 64'd1;
  localparam int WDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [31:0] energy;
    logic [1:0]         code;
  } energy_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic node_valid = 1'b0;
  logic node_ready;
  logic signed [31:0] disp_x = '0, disp_y = '0, grad_b = '0, grad_c = '0;
  logic [30:0] bulk_modulus = '0, shear_modulus = '0, elem_area = '0;
  logic last_element = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [31:0] mean_energy;
  logic [1:0] status;

  // predictor state
  longint unsigned ln1p_lut [0:256];
  int unsigned node_pos;
  longint acc00, acc01, acc10, acc11, energy_acc;
  longint unsigned area_acc;
  bit jac_bad;

  energy_result_t pending_means [$];
  int error_count = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mean_neo_hookean_energy_tri u_top (
    .clk(clk), .rst(rst),
    .node_valid(node_valid), .node_ready(node_ready),
    .disp_x(disp_x), .disp_y(disp_y), .grad_b(grad_b), .grad_c(grad_c),
    .bulk_modulus(bulk_modulus), .shear_modulus(shear_modulus),
    .elem_area(elem_area), .last_element(last_element),
    .result_valid(result_valid), .result_ready(result_ready),
    .mean_energy(mean_energy), .status(status)
  );

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // ln(1+x/2^30) in Q30 by the atanh series
  function automatic longint unsigned atanh_ln1p(longint unsigned x);
    longint unsigned y, y2, term, acc;
    y = (x << 30) / ((64'd1 << 31) + x);
    y2 = (y * y) >> 30;
    term = y;
    acc = 0;
    for (int n = 0; n < 16; n++) begin
      acc += term / (2 * n + 1);
      term = (term * y2) >> 30;
    end
    return 2 * acc;
  endfunction

  // natural log of a positive Q16.16 value, Q16.16 result
  function automatic longint ln_q(longint j);
    longint unsigned u, f, lo, hi, frac;
    int p;
    longint l30;
    u = j;
    p = 62;
    while (p > 0 && u[p] == 1'b0) p--;
    if (p >= 30) f = (u >> (p - 30)) - (64'd1 << 30);
    else f = (u << (30 - p)) - (64'd1 << 30);
    lo = ln1p_lut[(f >> 22) & 255];
    hi = ln1p_lut[((f >> 22) & 255) + 1];
    frac = lo + (((hi - lo) * (f & ((64'd1 << 22) - 1))) >> 22);
    l30 = longint'(p - FB) * LN2_FIXED + longint'(frac);
    return l30 >>> (30 - FB);
  endfunction

  task automatic predict_energy(logic signed [31:0] ux, logic signed [31:0] uy,
                                logic signed [31:0] gb, logic signed [31:0] gc,
                                logic [30:0] lam, logic [30:0] mu_in,
                                logic [30:0] area, logic last);
    longint f00, f01, f10, f11, jac, trc, dv, t1, t2, t3, we, prod;
    longint mu, lambda;
    energy_result_t r;
    acc00 += (longint'(ux) * longint'(gb)) >>> FB;
    acc01 += (longint'(ux) * longint'(gc)) >>> FB;
    acc10 += (longint'(uy) * longint'(gb)) >>> FB;
    acc11 += (longint'(uy) * longint'(gc)) >>> FB;
    if (node_pos < 2) begin
      node_pos++;
      return;
    end
    node_pos = 0;
    f00 = clamp32(acc00 + ONE);
    f01 = clamp32(acc01);
    f10 = clamp32(acc10);
    f11 = clamp32(acc11 + ONE);
    acc00 = 0; acc01 = 0; acc10 = 0; acc11 = 0;
    jac = ((f00 * f11) >>> FB) - ((f01 * f10) >>> FB);
    trc = ((f00 * f00) >>> FB) + ((f01 * f01) >>> FB)
        + ((f10 * f10) >>> FB) + ((f11 * f11) >>> FB);
    area_acc += area;
    if (area_acc > AREA_CAP) area_acc = AREA_CAP;
    mu = longint'(mu_in);
    lambda = longint'(lam);
    if (jac <= 0) begin
      jac_bad = 1'b1;
    end else begin
      t1 = (mu * clamp32(trc - 2 * ONE)) >>> (FB + 1);
      dv = clamp32(jac - ONE);
      t2 = (lambda * clamp32((dv * dv) >>> FB)) >>> (FB + 1);
      t3 = (mu * clamp32(ln_q(jac))) >>> FB;
      we = clamp32(t1 + t2 - t3);
      prod = longint'(area) * we;
      // saturating 64-bit accumulate
      if (prod > 0 && energy_acc > 64'sh7fff_ffff_ffff_ffff - prod)
        energy_acc = 64'sh7fff_ffff_ffff_ffff;
      else if (prod < 0 && energy_acc < 64'sh8000_0000_0000_0000 - prod)
        energy_acc = 64'sh8000_0000_0000_0000;
      else
        energy_acc += prod;
    end
    if (!last) return;
    r.energy = '0;
    if (jac_bad) r.code = mnhe_pkg::ST_BAD_JAC;
    else if (area_acc == 0) r.code = mnhe_pkg::ST_NO_AREA;
    else begin
      r.code = mnhe_pkg::ST_OK;
      r.energy = 32'(clamp32(energy_acc / longint'(area_acc)));
    end
    pending_means.push_back(r);
    energy_acc = 0;
    area_acc = 0;
    jac_bad = 1'b0;
  endtask

  // one node request; valid stays up across back-to-back requests
  task automatic send_node(logic signed [31:0] ux, logic signed [31:0] uy,
                           logic signed [31:0] gb, logic signed [31:0] gc,
                           logic [30:0] lam, logic [30:0] mu_in,
                           logic [30:0] area, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      node_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    node_valid <= 1'b1;
    disp_x <= ux; disp_y <= uy; grad_b <= gb; grad_c <= gc;
    bulk_modulus <= lam; shear_modulus <= mu_in; elem_area <= area;
    last_element <= last;
    @(posedge clk);
    while (!node_ready) @(posedge clk);
    predict_energy(ux, uy, gb, gc, lam, mu_in, area, last);
  endtask

  // three nodes with random displacement and gradient: small values when sane, full 32-bit range otherwise
  task automatic send_element(bit sane, logic [30:0] lam, logic [30:0] mu_in,
                              logic [30:0] area, logic last);
    for (int n = 0; n < 3; n++) begin
      if (sane)
        send_node(32'($urandom_range(0, 32'(2 * ONE)) - ONE),
                  32'($urandom_range(0, 32'(2 * ONE)) - ONE),
                  32'($urandom_range(0, 32'(ONE)) - ONE / 2),
                  32'($urandom_range(0, 32'(ONE)) - ONE / 2),
                  lam, mu_in, area, (n == 2) ? last : 1'($urandom));
      else
        send_node($urandom, $urandom, $urandom, $urandom, lam, mu_in, area,
                  (n == 2) ? last : 1'($urandom));
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // result checker and stall watchdog
  always @(posedge clk) begin
    energy_result_t exp_r;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_means.size() == 0) begin
          $error("unexpected result: mean_energy %0d status %0d", mean_energy, status);
          error_count++;
        end else begin
          exp_r = pending_means.pop_front();
          if (mean_energy !== exp_r.energy) begin
            $error("mean_energy: expected %0d, got %0d", exp_r.energy, mean_energy);
            error_count++;
          end
          if (status !== exp_r.code) begin
            $error("status: expected %0d, got %0d", exp_r.code, status);
            error_count++;
          end
        end
      end
      if ((node_valid && node_ready) || (result_valid && result_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no handshake in %0d cycles", WDOG_LIMIT);
        $display("mean_neo_hookean_energy_tri_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic test_field_extremes();
    // all-max, all-min and mixed-extreme nodes as one element, then a sane random element to end the batch
    send_node(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
              '1, '1, '1, 1'b1);
    send_node(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              '0, '0, '0, 1'b1);
    send_node(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
              '1, '1, '1, 1'b1);
    send_element(1'b1, 31'h10000, 31'h10000, 31'h10000, 1'b1);
  endtask

  task automatic test_identity_and_stretch();
    // zero displacement: energy exactly zero
    for (int n = 0; n < 3; n++)
      send_node(32'sd0, 32'sd0, 32'(ONE), 32'(ONE), 31'h10000, 31'h10000, 31'(ONE), n == 2);
    // uniform stretch, J > 1
    for (int n = 0; n < 3; n++)
      send_node(32'(ONE / 4), 32'(ONE / 4), 32'(ONE), 32'(ONE), 31'h20000, 31'h8000,
                31'(ONE), n == 2);
  endtask

  task automatic test_bad_jacobian();
    // F00 = -1 -> J < 0, status wins over zero area
    send_node(32'(-2 * ONE), 32'sd0, 32'(ONE), 32'sd0, 31'h10000, 31'h10000, 31'd0, 1'b0);
    send_node(32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd0, 31'd0, 1'b0);
    send_node(32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'h10000, 31'h10000, 31'd0, 1'b1);
    // J = 0 exactly
    send_node(32'(-ONE), 32'sd0, 32'(ONE), 32'sd0, 31'd0, 31'd0, 31'd0, 1'b0);
    send_node(32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd0, 31'd0, 1'b0);
    send_node(32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'h10000, 31'h10000, 31'(ONE), 1'b1);
  endtask

  task automatic test_zero_area();
    send_element(1'b1, 31'h10000, 31'h10000, 31'd0, 1'b0);
    send_element(1'b1, 31'h10000, 31'h10000, 31'd0, 1'b1);
  endtask

  task automatic test_energy_overflow();
    // huge stretch and moduli drive the energy sum into saturation
    for (int e = 0; e < 4; e++)
      for (int n = 0; n < 3; n++)
        send_node(32'sh0100_0000, 32'sh0100_0000, 32'(ONE), 32'(ONE), '1, '1, '1,
                  e == 3 && n == 2);
  endtask

  task automatic test_backpressure();
    // receiver holds off while elements keep coming; the block must stall its input
    hold_req = 1'b1;
    no_idle = 1'b1;
    for (int e = 0; e < 6; e++) send_element(1'b1, 31'h10000, 31'h8000, 31'h4000, 1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_random_stream(int elements);
    logic [30:0] lam, mu_in, area;
    for (int e = 0; e < elements; e++) begin
      if (e % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin lam = 31'($urandom); mu_in = 31'($urandom); end
        default: begin
          lam = 31'($urandom_range(0, 1 << 20));
          mu_in = 31'($urandom_range(0, 1 << 20));
        end
      endcase
      case ($urandom_range(0, 9))
        0: area = 31'd0;
        1: area = 31'($urandom);
        default: area = 31'($urandom_range(1, 1 << 20));
      endcase
      send_element($urandom_range(0, 9) < 8, lam, mu_in, area, $urandom_range(0, 7) == 0);
    end
    no_idle = 1'b0;
    send_element(1'b1, 31'h10000, 31'h10000, 31'h10000, 1'b1);
  endtask

  initial begin
    int waited;
    for (int k = 0; k <= 256; k++) ln1p_lut[k] = atanh_ln1p(longint'(k) << 22);
    node_pos = 0;
    acc00 = 0; acc01 = 0; acc10 = 0; acc11 = 0;
    energy_acc = 0; area_acc = 0; jac_bad = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_identity_and_stretch();
    test_bad_jacobian();
    test_zero_area();
    test_energy_overflow();
    test_backpressure();
    test_random_stream(440);

    @(posedge clk);
    node_valid <= 1'b0;
    waited = 0;
    while (pending_means.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (error_count == 0 && pending_means.size() == 0) begin
      $display("mean_neo_hookean_energy_tri_tb: done, clean");
    end else begin
      if (pending_means.size() != 0)
        $error("%0d expected results never arrived", pending_means.size());
      $display("mean_neo_hookean_energy_tri_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mnhe_pkg.sv
rtl/mnhe_fifo.sv
rtl/mnhe_front.sv
rtl/mnhe_div.sv
rtl/mnhe_back.sv
rtl/mean_neo_hookean_energy_tri.sv
bench/mean_neo_hookean_energy_tri_tb.sv
